// ----- src/qgp_pkg.sv -----
package qgp_pkg;

	localparam int PW = 43;
	localparam int NW = 32;
	localparam int QW = 61;
	localparam int SW = 63;
	localparam int RW = 31;
	localparam int AW = 46;
	localparam int QB = 15;
	localparam int LW = 6;
	localparam int UNIT = 16384;

	typedef logic signed [PW-1:0] prop_t;
	typedef logic signed [NW-1:0] pn_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
		logic signed [23:0] rate_x;
		logic signed [23:0] rate_y;
		logic signed [23:0] rate_z;
		logic [23:0] step_time;
	} in_req_t;

	typedef struct packed {
		logic signed [15:0] next_w;
		logic signed [15:0] next_x;
		logic signed [15:0] next_y;
		logic signed [15:0] next_z;
		logic zero_norm;
	} out_req_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

endpackage

// ----- src/qgp_prop.sv -----
module qgp_prop (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  qgp_pkg::in_req_t req,
	output logic             p_valid,
	output qgp_pkg::prop_t   p [4]
);
	import qgp_pkg::*;

	logic signed [15:0] q_in [4];
	logic signed [23:0] u_in [3];

	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [39:0] prod_s1 [3][4];
	logic signed [15:0] q_s1 [4], q_s2 [4], q_s3 [4];
	logic [23:0]        dt_s1, dt_s2;
	logic signed [41:0] d_s2 [4];
	logic signed [54:0] a_s3 [4], b_s3 [4];
	prop_t              p_s4 [4];

	logic signed [12:0] dt_hi, dt_lo;
	logic signed [55:0] t_c [4];
	logic signed [55:0] pf_c [4];

	assign q_in[0] = req.quat_w;
	assign q_in[1] = req.quat_x;
	assign q_in[2] = req.quat_y;
	assign q_in[3] = req.quat_z;
	assign u_in[0] = req.rate_x;
	assign u_in[1] = req.rate_y;
	assign u_in[2] = req.rate_z;

	assign dt_hi = $signed({1'b0, dt_s2[23:12]});
	assign dt_lo = $signed({1'b0, dt_s2[11:0]});

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			t_c[i]  = 56'(a_s3[i]) + 56'sd4096 + 56'(b_s3[i] >>> 12);
			pf_c[i] = (56'(q_s3[i]) <<< 16) + (t_c[i] >>> 13);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 4; b++) begin
					prod_s1[a][b] <= u_in[a] * q_in[b];
				end
			end
			q_s1  <= q_in;
			dt_s1 <= req.step_time;

			d_s2[0] <= -42'(prod_s1[0][1]) - 42'(prod_s1[1][2]) - 42'(prod_s1[2][3]);
			d_s2[1] <=  42'(prod_s1[0][0]) + 42'(prod_s1[2][2]) - 42'(prod_s1[1][3]);
			d_s2[2] <=  42'(prod_s1[1][0]) - 42'(prod_s1[2][1]) + 42'(prod_s1[0][3]);
			d_s2[3] <=  42'(prod_s1[2][0]) + 42'(prod_s1[1][1]) - 42'(prod_s1[0][2]);
			q_s2  <= q_s1;
			dt_s2 <= dt_s1;

			for (int i = 0; i < 4; i++) begin
				a_s3[i] <= d_s2[i] * dt_hi;
				b_s3[i] <= d_s2[i] * dt_lo;
				p_s4[i] <= pf_c[i][PW-1:0];
			end
			q_s3 <= q_s2;
		end
	end

	assign p_valid = v_s4;
	assign p       = p_s4;

endmodule

// ----- src/qgp_norm.sv -----
module qgp_norm (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          p_valid,
	input  qgp_pkg::prop_t                p [4],
	output qgp_pkg::ctl_t                 ctl,
	output qgp_pkg::pn_t                  pn [4],
	output logic [qgp_pkg::SW-1:0]        sum
);
	import qgp_pkg::*;

	logic            v_s1, v_s2, v_s3, v_s4, v_s5;
	logic            z_s3, z_s4, z_s5;
	logic [PW-2:0]   orw_s1;
	prop_t           p_s1 [4], p_s2 [4];
	logic [LW-1:0]   len_s2;
	logic            z_s2;
	pn_t             pn_s3 [4], pn_s4 [4], pn_s5 [4];
	logic [QW-1:0]   sq_s4 [4];
	logic [SW-1:0]   sum_s5;

	logic [PW-2:0]   orw_c;
	prop_t           mag_c;
	logic [LW-1:0]   len_c;
	logic signed [PW+29:0] pe_c [4];
	logic signed [PW+29:0] sh_c [4];
	logic signed [63:0]    sq_c [4];

	always_comb begin
		orw_c = '0;
		for (int i = 0; i < 4; i++) begin
			mag_c = p[i][PW-1] ? -p[i] : p[i];
			orw_c = orw_c | mag_c[PW-2:0];
		end
	end

	always_comb begin
		len_c = '0;
		for (int b = 0; b < PW-1; b++) begin
			if (orw_s1[b]) begin
				len_c = LW'(b + 1);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			pe_c[i] = $signed({p_s2[i], 30'b0});
			sh_c[i] = pe_c[i] >>> len_s2;
			sq_c[i] = pn_s3[i] * pn_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= p_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			orw_s1 <= orw_c;
			p_s1   <= p;
			len_s2 <= len_c;
			z_s2   <= (orw_s1 == '0);
			p_s2   <= p_s1;
			z_s3   <= z_s2;
			z_s4   <= z_s3;
			z_s5   <= z_s4;
			for (int i = 0; i < 4; i++) begin
				pn_s3[i] <= sh_c[i][NW-1:0];
				sq_s4[i] <= sq_c[i][QW-1:0];
			end
			pn_s4  <= pn_s3;
			pn_s5  <= pn_s4;
			sum_s5 <= SW'(sq_s4[0]) + SW'(sq_s4[1]) + SW'(sq_s4[2]) + SW'(sq_s4[3]);
		end
	end

	assign ctl.valid = v_s5;
	assign ctl.zero  = z_s5;
	assign pn        = pn_s5;
	assign sum       = sum_s5;

endmodule

// ----- src/qgp_sqrt.sv -----
module qgp_sqrt (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  qgp_pkg::ctl_t          ctl_in,
	input  qgp_pkg::pn_t           pn_in [4],
	input  logic [qgp_pkg::SW-1:0] sum,
	output qgp_pkg::ctl_t          ctl,
	output qgp_pkg::pn_t           pn [4],
	output logic [qgp_pkg::RW-1:0] root
);
	import qgp_pkg::*;

	ctl_t          ctl_s  [RW];
	pn_t           pn_s   [RW][4];
	logic [SW-1:0] rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar i = 0; i < RW; i++) begin : g_step
		localparam int K = RW - 1 - i;
		ctl_t          c_in;
		pn_t           p_in [4];
		logic [SW-1:0] r_in;
		logic [RW-1:0] t_in;
		logic [63:0]   trial;
		logic          take;

		if (i == 0) begin : g_first
			assign c_in = ctl_in;
			assign p_in = pn_in;
			assign r_in = sum;
			assign t_in = '0;
		end else begin : g_next
			assign c_in = ctl_s[i-1];
			assign p_in = pn_s[i-1];
			assign r_in = rem_s[i-1];
			assign t_in = root_s[i-1];
		end

		assign trial = (64'(t_in) << (K + 1)) | (64'd1 << (2 * K));
		assign take  = ({1'b0, r_in} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= c_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pn_s[i]   <= p_in;
				rem_s[i]  <= take ? SW'(64'(r_in) - trial) : r_in;
				root_s[i] <= take ? (t_in | (RW'(1) << K)) : t_in;
			end
		end
	end

	assign ctl  = ctl_s[RW-1];
	assign pn   = pn_s[RW-1];
	assign root = root_s[RW-1];

endmodule

// ----- src/qgp_div.sv -----
module qgp_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  qgp_pkg::ctl_t          ctl_in,
	input  qgp_pkg::pn_t           pn [4],
	input  logic [qgp_pkg::RW-1:0] root,
	output qgp_pkg::ctl_t          ctl,
	output logic [qgp_pkg::QB-1:0] quo [4],
	output logic [3:0]             neg
);
	import qgp_pkg::*;

	ctl_t          ctl_s [QB+1];
	logic [AW-1:0] rem_s [QB+1][4];
	logic [QB-1:0] quo_s [QB+1][4];
	logic [RW-1:0] r_s   [QB+1];
	logic [3:0]    neg_s [QB+1];

	pn_t           mag_c [4];
	logic [AW-1:0] num_c [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = pn[i][NW-1] ? -pn[i] : pn[i];
			num_c[i] = (AW'(mag_c[i]) << 14) + AW'(root >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else if (en) begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s[0] <= root;
			for (int i = 0; i < 4; i++) begin
				rem_s[0][i]  <= num_c[i];
				quo_s[0][i]  <= '0;
				neg_s[0][i]  <= pn[i][NW-1];
			end
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam int B = QB - j;
		logic [AW-1:0] dv;

		assign dv = AW'(r_s[j-1]) << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[j] <= '0;
			end else if (en) begin
				ctl_s[j] <= ctl_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				r_s[j]   <= r_s[j-1];
				neg_s[j] <= neg_s[j-1];
				for (int i = 0; i < 4; i++) begin
					if (rem_s[j-1][i] >= dv) begin
						rem_s[j][i] <= rem_s[j-1][i] - dv;
						quo_s[j][i] <= quo_s[j-1][i] | (QB'(1) << B);
					end else begin
						rem_s[j][i] <= rem_s[j-1][i];
						quo_s[j][i] <= quo_s[j-1][i];
					end
				end
			end
		end
	end

	assign ctl = ctl_s[QB];
	assign quo = quo_s[QB];
	assign neg = neg_s[QB];

endmodule

// ----- src/quaternion_gyro_propagate_core.sv -----
// Channel   | Handshake                      | Payload
// ----------+--------------------------------+---------------------------------
// sample    | sample_valid / sample_stall    | quaternion, body rate, time step
// attitude  | attitude_valid / attitude_stall| unit quaternion, zero_norm flag
//
// One request per cycle while the attitude register is not held full and stalled.
// The 31-step square root and 15-step divider pipelines make up most of its depth.
// arst_n clears the valid bits and the zero flags in the square root and divider; other payload is left as it is.
// The whole pipeline holds while the attitude register is full and stalled.
module quaternion_gyro_propagate_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sample_valid,
	output logic              sample_stall,
	input  qgp_pkg::in_req_t  sample,
	output logic              attitude_valid,
	input  logic              attitude_stall,
	output qgp_pkg::out_req_t attitude
);
	import qgp_pkg::*;

	logic          en;
	logic          p_valid;
	prop_t         p [4];
	ctl_t          n_ctl, s_ctl, d_ctl;
	pn_t           n_pn [4], s_pn [4];
	logic [SW-1:0] n_sum;
	logic [RW-1:0] s_root;
	logic [QB-1:0] d_quo [4];
	logic [3:0]    d_neg;

	logic          out_valid_q;
	out_req_t      out_q;
	logic [15:0]   val_c [4];
	logic [QB-1:0] sat_c;

	assign en           = !(out_valid_q && attitude_stall);
	assign sample_stall = !en;

	qgp_prop u_prop (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (sample_valid),
		.req      (sample),
		.p_valid  (p_valid),
		.p        (p)
	);

	qgp_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.p_valid (p_valid),
		.p       (p),
		.ctl     (n_ctl),
		.pn      (n_pn),
		.sum     (n_sum)
	);

	qgp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (n_ctl),
		.pn_in  (n_pn),
		.sum    (n_sum),
		.ctl    (s_ctl),
		.pn     (s_pn),
		.root   (s_root)
	);

	qgp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_in (s_ctl),
		.pn     (s_pn),
		.root   (s_root),
		.ctl    (d_ctl),
		.quo    (d_quo),
		.neg    (d_neg)
	);

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sat_c    = (d_quo[i] > QB'(UNIT)) ? QB'(UNIT) : d_quo[i];
			val_c[i] = d_ctl.zero ? 16'd0 : (d_neg[i] ? -16'(sat_c) : 16'(sat_c));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d_ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.next_w    <= val_c[0];
			out_q.next_x    <= val_c[1];
			out_q.next_y    <= val_c[2];
			out_q.next_z    <= val_c[3];
			out_q.zero_norm <= d_ctl.zero;
		end
	end

	assign attitude_valid = out_valid_q;
	assign attitude       = out_q;

	a_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		attitude_valid && attitude.zero_norm |->
			attitude.next_w == 16'sd0 && attitude.next_x == 16'sd0 &&
			attitude.next_y == 16'sd0 && attitude.next_z == 16'sd0)
		else $error("zero_norm result carries nonzero components");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		attitude_valid |->
			attitude.next_w <= 16'sd16384 && attitude.next_w >= -16'sd16384 &&
			attitude.next_x <= 16'sd16384 && attitude.next_x >= -16'sd16384 &&
			attitude.next_y <= 16'sd16384 && attitude.next_y >= -16'sd16384 &&
			attitude.next_z <= 16'sd16384 && attitude.next_z >= -16'sd16384)
		else $error("result component outside unit range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |=> $stable(attitude) && attitude_valid)
		else $error("pipeline advanced while output held");

endmodule

// ----- bench/quaternion_gyro_propagate_core_tb.sv -----
module quaternion_gyro_propagate_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qgp_pkg::*;

	localparam int LATENCY = 57;
	localparam longint CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_stall;
	in_req_t sample;
	logic attitude_valid;
	logic attitude_stall;
	out_req_t attitude;

	in_req_t pending_q[$];
	out_req_t attitude_exp_q[$];
	int idle_pct;
	int stall_pct;
	int mismatches;
	int requests_sent;
	int attitudes_seen;
	int zero_norm_seen;
	longint cycles;
	logic sample_taken;

	quaternion_gyro_propagate_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.attitude_valid(attitude_valid),
		.attitude_stall(attitude_stall),
		.attitude(attitude)
	);

	function automatic longint floor_shr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint int_sqrt(longint unsigned s);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s)
			bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic out_req_t propagate_attitude(in_req_t s);
		longint q[4];
		longint u[3];
		longint d[4];
		longint p[4];
		longint dt_hi;
		longint dt_lo;
		longint unsigned m;
		longint unsigned sum;
		longint unsigned r;
		longint unsigned mag;
		longint unsigned an;
		longint unsigned qq;
		longint num;
		longint v[4];
		int len;
		out_req_t o;
		q[0] = s.quat_w;
		q[1] = s.quat_x;
		q[2] = s.quat_y;
		q[3] = s.quat_z;
		u[0] = s.rate_x;
		u[1] = s.rate_y;
		u[2] = s.rate_z;
		dt_hi = longint'(s.step_time >> 12);
		dt_lo = longint'(s.step_time & 24'hFFF);
		d[0] = -u[0] * q[1] - u[1] * q[2] - u[2] * q[3];
		d[1] = u[0] * q[0] + u[2] * q[2] - u[1] * q[3];
		d[2] = u[1] * q[0] - u[2] * q[1] + u[0] * q[3];
		d[3] = u[2] * q[0] + u[1] * q[1] - u[0] * q[2];
		m = 0;
		for (int i = 0; i < 4; i++) begin
			p[i] = q[i] * 65536 + floor_shr(d[i] * dt_hi + 4096
				+ floor_shr(d[i] * dt_lo, 12), 13);
			mag = p[i] < 0 ? longint'(-p[i]) : longint'(p[i]);
			if (mag > m)
				m = mag;
		end
		o = '0;
		if (m == 0) begin
			o.zero_norm = 1'b1;
			return o;
		end
		len = 0;
		while (len < 64 && (m >> len) != 0)
			len++;
		sum = 0;
		for (int i = 0; i < 4; i++) begin
			if (len > 30)
				p[i] = floor_shr(p[i], len - 30);
			else if (len < 30)
				p[i] = p[i] <<< (30 - len);
			sum += longint'(p[i] * p[i]);
		end
		r = int_sqrt(sum);
		for (int i = 0; i < 4; i++) begin
			num = p[i] * 16384;
			an = num < 0 ? longint'(-num) : longint'(num);
			v[i] = 0;
			if (r != 0) begin
				qq = (an + r / 2) / r;
				if (qq > UNIT)
					qq = UNIT;
				v[i] = num < 0 ? -longint'(qq) : longint'(qq);
			end
		end
		o.next_w = v[0][15:0];
		o.next_x = v[1][15:0];
		o.next_y = v[2][15:0];
		o.next_z = v[3][15:0];
		return o;
	endfunction

	function automatic logic signed [15:0] rand_quat_comp();
		case ($urandom_range(0, 9))
			0: return 16'(16384);
			1: return -16'sd16384;
			2: return 16'($urandom);
			3: return 16'($urandom_range(0, 64)) - 16'sd32;
			default: return 16'($urandom_range(0, 32768)) - 16'sd16384;
		endcase
	endfunction

	function automatic logic signed [23:0] rand_rate();
		case ($urandom_range(0, 7))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom);
			3: return 24'($urandom_range(0, 2000)) - 24'sd1000;
			default: return 24'($urandom_range(0, 2000000)) - 24'sd1000000;
		endcase
	endfunction

	function automatic in_req_t rand_sample();
		in_req_t s;
		s.quat_w = rand_quat_comp();
		s.quat_x = rand_quat_comp();
		s.quat_y = rand_quat_comp();
		s.quat_z = rand_quat_comp();
		s.rate_x = rand_rate();
		s.rate_y = rand_rate();
		s.rate_z = rand_rate();
		case ($urandom_range(0, 5))
			0: s.step_time = 24'hFFFFFF;
			1: s.step_time = 24'($urandom_range(0, 16));
			2: s.step_time = 24'($urandom);
			default: s.step_time = 24'($urandom_range(0, 100000));
		endcase
		return s;
	endfunction

	function automatic in_req_t make_sample(int w, int x, int y, int z,
		int rx, int ry, int rz, int dt);
		in_req_t s;
		s.quat_w = 16'(w);
		s.quat_x = 16'(x);
		s.quat_y = 16'(y);
		s.quat_z = 16'(z);
		s.rate_x = 24'(rx);
		s.rate_y = 24'(ry);
		s.rate_z = 24'(rz);
		s.step_time = 24'(dt);
		return s;
	endfunction

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_valid <= 1'b0;
			sample <= '0;
			attitude_stall <= 1'b0;
		end else begin
			attitude_stall <= ($urandom_range(0, 99) < stall_pct);
			if (!sample_valid || sample_taken) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					sample <= pending_q.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			cycles <= cycles + 1;
			sample_taken <= sample_valid && !sample_stall;
			if (sample_valid && !sample_stall) begin
				attitude_exp_q.push_back(propagate_attitude(sample));
				requests_sent <= requests_sent + 1;
			end
			if (attitude_valid && !attitude_stall) begin
				attitudes_seen <= attitudes_seen + 1;
				if (attitude.zero_norm)
					zero_norm_seen <= zero_norm_seen + 1;
				if (attitude_exp_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected attitude %h", attitude);
				end else begin
					out_req_t e;
					e = attitude_exp_q.pop_front();
					if (e !== attitude) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: exp w=%0d x=%0d y=%0d z=%0d zn=%0b got w=%0d x=%0d y=%0d z=%0d zn=%0b",
								e.next_w, e.next_x, e.next_y, e.next_z, e.zero_norm,
								attitude.next_w, attitude.next_x, attitude.next_y,
								attitude.next_z, attitude.zero_norm);
					end
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("quaternion_gyro_propagate_core_tb: errors");
				$finish;
			end
		end
	end

	task automatic run_phase(int idle, int stall, int count);
		idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			pending_q.push_back(rand_sample());
		wait (pending_q.size() == 0);
	endtask

	initial begin
		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		attitude_stall = 1'b0;
		sample_taken = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		requests_sent = 0;
		attitudes_seen = 0;
		zero_norm_seen = 0;
		cycles = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		pending_q.push_back(make_sample(16384, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_sample(0, 0, 0, 0, 65536, -65536, 100, 16777215));
		pending_q.push_back(make_sample(-16384, 16384, -16384, 16384, 0, 0, 0, 0));
		pending_q.push_back(make_sample(32767, -32768, 32767, -32768, 8388607, 8388607,
			8388607, 16777215));
		pending_q.push_back(make_sample(-32768, -32768, -32768, -32768, -8388608, -8388608,
			-8388608, 16777215));
		pending_q.push_back(make_sample(1, 0, 0, 0, 0, 0, 0, 0));
		pending_q.push_back(make_sample(0, 0, 0, -1, 0, 0, 0, 1));
		pending_q.push_back(make_sample(16384, 0, 0, 0, 8388607, 0, 0, 16777215));
		pending_q.push_back(make_sample(16384, 0, 0, 0, 0, -8388608, 0, 16777215));
		pending_q.push_back(make_sample(0, 16384, 0, 0, 0, 0, 8388607, 16777215));
		pending_q.push_back(make_sample(11585, 11585, 0, 0, 65536, 0, 0, 167772));
		pending_q.push_back(make_sample(8192, 8192, 8192, 8192, 1, -1, 1, 1));
		pending_q.push_back(make_sample(16384, 0, 0, 0, 65536, 65536, 65536, 16777215));
		pending_q.push_back(make_sample(0, 0, 1, 0, 8388607, -8388608, 8388607, 16777215));
		pending_q.push_back(make_sample(16383, -16383, 0, 1, -1, -1, -1, 4096));
		wait (pending_q.size() == 0);

		run_phase(0, 0, 500);
		wait (attitude_exp_q.size() == 0);
		run_phase(73, 0, 450);
		run_phase(0, 73, 450);
		run_phase(20, 20, 550);
		wait (attitude_exp_q.size() == 0 && !sample_valid);
		repeat (4 * LATENCY) @(posedge clk);

		$display("sent %0d samples, checked %0d attitudes (%0d with zero norm), idle/stall mixes 0/0 73/0 0/73 20/20",
			requests_sent, attitudes_seen, zero_norm_seen);
		if (mismatches == 0 && attitude_exp_q.size() == 0) begin
			$display("quaternion_gyro_propagate_core_tb: clean");
		end else begin
			$display("%0d mismatches, %0d attitudes missing", mismatches, attitude_exp_q.size());
			$display("quaternion_gyro_propagate_core_tb: errors");
		end
		$finish;
	end
endmodule

// ----- files.f -----
src/qgp_pkg.sv
src/qgp_prop.sv
src/qgp_norm.sv
src/qgp_sqrt.sv
src/qgp_div.sv
src/quaternion_gyro_propagate_core.sv
bench/quaternion_gyro_propagate_core_tb.sv
